// ===== design/rrs_pkg.sv =====
// Shared widths, codes and side-band types for the rounded rectangle row span unit.
`default_nettype none

package rrs_pkg;

  // Row and span coordinate width on the streaming ports.
  localparam int COORD_BITS = 15;

  // Configuration field widths.
  localparam int POS_W      = 14;
  localparam int DIM_W      = 12;
  localparam int CFG_DATA_W = POS_W;
  localparam int CFG_IDX_W  = 3;

  // Clamped radius is at most half of a 12-bit side.
  localparam int RW       = DIM_W - 1;
  localparam int RAD_W    = 2 * RW;
  localparam int SQ_STEPS = RW;

  // Span arithmetic width (left column plus width plus inset) and row distance width.
  localparam int XW = (COORD_BITS > 16) ? COORD_BITS : 17;
  localparam int DW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;

  // Stream payload widths, padded to whole bytes.
  localparam int TDATA_IN_W  = ((COORD_BITS + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT,
    REG_RECT_TOP,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_CORNER_RADIUS
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FLAT,
    MODE_FULL,
    MODE_ROOT,
    MODE_EMPTY
  } inset_mode_e;

  typedef struct packed {
    logic signed [XW-1:0] left;
    logic signed [XW-1:0] right;
    logic [RW-1:0]        r_m1;
    inset_mode_e          mode;
  } rrs_side_t;

endpackage

`default_nettype wire

// ===== design/rrs_sqrt_pipe.sv =====
// Pipelined bit-by-bit integer square root, one result bit per stage, with side band.
`default_nettype none

module rrs_sqrt_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rrs_pkg::RAD_W-1:0]  in_rad_i,
  input  rrs_pkg::rrs_side_t         in_side_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rrs_pkg::RW-1:0]     out_root_o,
  output rrs_pkg::rrs_side_t         out_side_o
);
  import rrs_pkg::*;

  localparam int Last = SQ_STEPS - 1;

  logic [SQ_STEPS-1:0] vld_q;
  logic [SQ_STEPS:0]   rdy;
  logic [RAD_W-1:0]    rem_q  [SQ_STEPS];
  logic [RAD_W-1:0]    root_q [SQ_STEPS];
  rrs_side_t           side_q [SQ_STEPS];

  assign rdy[SQ_STEPS] = out_ready_i;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int BitPos = 2 * (SQ_STEPS - 1 - k);

    logic             vld_in;
    logic [RAD_W-1:0] rem_in;
    logic [RAD_W-1:0] root_in;
    rrs_side_t        side_in;
    logic [RAD_W-1:0] bit_v;
    logic [RAD_W:0]   trial;
    logic             take;
    logic [RAD_W-1:0] rem_d;
    logic [RAD_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rem_in  = in_rad_i;
      assign root_in = '0;
      assign side_in = in_side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign bit_v  = RAD_W'(1) << BitPos;
    assign trial  = {1'b0, root_in} + {1'b0, bit_v};
    assign take   = {1'b0, rem_in} >= trial;
    assign rem_d  = take ? (rem_in - trial[RAD_W-1:0]) : rem_in;
    assign root_d = take ? ((root_in >> 1) + bit_v) : (root_in >> 1);

    assign rdy[k] = ~vld_q[k] | rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Last];
  assign out_root_o  = root_q[Last][RW-1:0];
  assign out_side_o  = side_q[Last];

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Last] |-> root_q[Last][RAD_W-1:RW] == '0)
    else $error("square root exceeds radius width");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Last] |-> rem_q[Last] <= {root_q[Last][RAD_W-2:0], 1'b0})
    else $error("square root remainder too large");

  a_empty_tail_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Last] |-> in_ready_o)
    else $error("sqrt pipe stalls with empty last stage");

endmodule

`default_nettype wire

// ===== design/rounded_rect_row_span_unit.sv =====
// Top level of the rounded rectangle row span unit: config registers and span pipeline.
//
// Usage: write the rectangle (left, top, width, height, corner radius) over the
// cfg channel (index 0..4, other indexes are dropped), then stream row
// coordinates into s_axis. For every row one span request leaves on m_axis:
// first and last covered column in tdata, and a valid flag in tuser that is
// low for an empty rectangle; a row above or below the rectangle still gets a span.
// The pipeline has 18 register stages: five front stages (setup, row distance,
// band decode, squares, radicand), eleven square root stages (one root bit
// each), the inset stage and the output register. Throughput is one row per
// cycle while m_axis_tready stays high; the eleven-step square root pipeline
// sets the depth, not the rate.
// Every stage carries its own valid bit and advances when the next stage is
// empty or moving, so bubbles close up and a new row is taken while a span
// waits at the output. When m_axis_tready is low the output holds and the
// stages behind it fill up; s_axis_tready drops only once all are full.
// Reset empties the pipeline and clears all config registers (empty
// rectangle). The cfg channel is always ready; write it only while idle.
`default_nettype none

module rounded_rect_row_span_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rrs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Row stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rrs_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // row_y
  // Span stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rrs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,   // span_left, span_right
  output logic [0:0]                        m_axis_tuser    // span_valid
);
  import rrs_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] cfg_left_q;
  logic signed [POS_W-1:0] cfg_top_q;
  logic [DIM_W-1:0]        cfg_width_q;
  logic [DIM_W-1:0]        cfg_height_q;
  logic [DIM_W-1:0]        cfg_radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_left_q   <= '0;
      cfg_top_q    <= '0;
      cfg_width_q  <= '0;
      cfg_height_q <= '0;
      cfg_radius_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RECT_LEFT:     cfg_left_q   <= cfg_data_i;
        REG_RECT_TOP:      cfg_top_q    <= cfg_data_i;
        REG_RECT_WIDTH:    cfg_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_RECT_HEIGHT:   cfg_height_q <= cfg_data_i[DIM_W-1:0];
        REG_CORNER_RADIUS: cfg_radius_q <= cfg_data_i[DIM_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front pipeline handshake: stages 0..4, then the square root pipe
  // ---------------------------------------------------------------------------
  logic [4:0] fv_q;
  logic [5:0] frdy;
  logic       sq_in_ready;

  assign frdy[5] = sq_in_ready;
  for (genvar k = 0; k < 5; k++) begin : g_front_rdy
    assign frdy[k] = ~fv_q[k] | frdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (frdy[0]) fv_q[0] <= s_axis_tvalid;
      if (frdy[1]) fv_q[1] <= fv_q[0];
      if (frdy[2]) fv_q[2] <= fv_q[1];
      if (frdy[3]) fv_q[3] <= fv_q[2];
      if (frdy[4]) fv_q[4] <= fv_q[3];
    end
  end

  assign s_axis_tready = frdy[0];

  // ---------------------------------------------------------------------------
  // Stage 1: clamp the radius, build the rectangle edges and corner centre rows
  // ---------------------------------------------------------------------------
  logic [RW-1:0]          half_w, half_h, max_r, rad_clamp;
  logic signed [XW-1:0]   left_x, width_x, right_x;
  logic signed [DW-1:0]   top_d, height_d, rad_d, row_d, cyt_d, cyb_d;
  logic signed [COORD_BITS-1:0] row_y;

  assign half_w    = cfg_width_q[DIM_W-1:1];
  assign half_h    = cfg_height_q[DIM_W-1:1];
  assign max_r     = (half_h < half_w) ? half_h : half_w;
  assign rad_clamp = (cfg_radius_q > {1'b0, max_r}) ? max_r : cfg_radius_q[RW-1:0];

  assign left_x  = XW'(cfg_left_q);
  assign width_x = XW'(cfg_width_q);
  assign right_x = left_x + width_x - XW'(1);

  assign row_y    = s_axis_tdata[COORD_BITS-1:0];
  assign row_d    = DW'(row_y);
  assign top_d    = DW'(cfg_top_q);
  assign height_d = DW'(cfg_height_q);
  assign rad_d    = DW'(rad_clamp);
  // Corner centre rows: top band ends before top+r-1, bottom band starts after bottom-(r-1).
  assign cyt_d    = top_d + rad_d - DW'(1);
  assign cyb_d    = top_d + height_d - rad_d;

  logic signed [DW-1:0] s1_y_q, s1_cyt_q, s1_cyb_q;
  logic signed [XW-1:0] s1_left_q, s1_right_q;
  logic [RW-1:0]        s1_r_q;
  logic                 s1_empty_q;

  always_ff @(posedge clk_i) begin
    if (frdy[0] && s_axis_tvalid) begin
      s1_y_q     <= row_d;
      s1_cyt_q   <= cyt_d;
      s1_cyb_q   <= cyb_d;
      s1_left_q  <= left_x;
      s1_right_q <= right_x;
      s1_r_q     <= rad_clamp;
      s1_empty_q <= (cfg_width_q == '0) || (cfg_height_q == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: row distance to each corner centre row
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] s2_dtop_q, s2_dbot_q;
  logic signed [XW-1:0] s2_left_q, s2_right_q;
  logic [RW-1:0]        s2_r_q;
  logic                 s2_empty_q;

  always_ff @(posedge clk_i) begin
    if (frdy[1] && fv_q[0]) begin
      s2_dtop_q  <= s1_cyt_q - s1_y_q;
      s2_dbot_q  <= s1_y_q - s1_cyb_q;
      s2_left_q  <= s1_left_q;
      s2_right_q <= s1_right_q;
      s2_r_q     <= s1_r_q;
      s2_empty_q <= s1_empty_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pick the band and decide how the inset is formed
  // ---------------------------------------------------------------------------
  logic          above, below, in_band, far;
  logic [DW-1:0] dy;
  inset_mode_e   mode;
  rrs_side_t     s3_side_d;

  assign above   = !s2_dtop_q[DW-1] && (s2_dtop_q != '0);
  assign below   = !s2_dbot_q[DW-1] && (s2_dbot_q != '0);
  assign in_band = above || below;
  assign dy      = above ? s2_dtop_q : (below ? s2_dbot_q : '0);
  assign far     = dy >= DW'(s2_r_q);

  always_comb begin
    priority if (s2_empty_q)                 mode = MODE_EMPTY;
    else if (s2_r_q == '0 || !in_band)       mode = MODE_FLAT;
    else if (far)                            mode = MODE_FULL;
    else                                     mode = MODE_ROOT;
  end

  assign s3_side_d.left  = s2_left_q;
  assign s3_side_d.right = s2_right_q;
  assign s3_side_d.r_m1  = s2_r_q - RW'(1);
  assign s3_side_d.mode  = mode;

  logic [RW-1:0] s3_dy_q, s3_r_q;
  rrs_side_t     s3_side_q;

  always_ff @(posedge clk_i) begin
    if (frdy[2] && fv_q[1]) begin
      s3_dy_q   <= dy[RW-1:0];  // only used in root mode, where dy < r
      s3_r_q    <= s2_r_q;
      s3_side_q <= s3_side_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squares of radius and row distance
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0] rsq_d, dsq_d;
  logic [RAD_W-1:0] s4_rsq_q, s4_dsq_q;
  rrs_side_t        s4_side_q;

  assign rsq_d = RAD_W'(s3_r_q) * RAD_W'(s3_r_q);
  assign dsq_d = RAD_W'(s3_dy_q) * RAD_W'(s3_dy_q);

  always_ff @(posedge clk_i) begin
    if (frdy[3] && fv_q[2]) begin
      s4_rsq_q  <= rsq_d;
      s4_dsq_q  <= dsq_d;
      s4_side_q <= s3_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: radicand r*r - dy*dy
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0] s5_rad_q;
  rrs_side_t        s5_side_q;

  always_ff @(posedge clk_i) begin
    if (frdy[4] && fv_q[3]) begin
      s5_rad_q  <= s4_rsq_q - s4_dsq_q;
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root pipeline
  // ---------------------------------------------------------------------------
  logic          sq_out_valid, sq_out_ready;
  logic [RW-1:0] sq_root;
  rrs_side_t     sq_side;

  rrs_sqrt_pipe u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fv_q[4]),
    .in_ready_o  (sq_in_ready),
    .in_rad_i    (s5_rad_q),
    .in_side_i   (s5_side_q),
    .out_valid_o (sq_out_valid),
    .out_ready_i (sq_out_ready),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // ---------------------------------------------------------------------------
  // Inset stage and output register handshake
  // ---------------------------------------------------------------------------
  logic f1_v_q, f1_rdy;
  logic out_v_q, out_rdy;

  assign out_rdy      = ~out_v_q | m_axis_tready;
  assign f1_rdy       = ~f1_v_q | out_rdy;
  assign sq_out_ready = f1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (f1_rdy)  f1_v_q  <= sq_out_valid;
      if (out_rdy) out_v_q <= f1_v_q;
    end
  end

  logic [RW-1:0] inset_d;

  always_comb begin
    unique case (sq_side.mode)
      MODE_FLAT:  inset_d = '0;
      MODE_EMPTY: inset_d = '0;
      MODE_FULL:  inset_d = sq_side.r_m1;
      MODE_ROOT:  inset_d = (sq_root > sq_side.r_m1) ? '0 : (sq_side.r_m1 - sq_root);
    endcase
  end

  logic [RW-1:0] f1_inset_q;
  rrs_side_t     f1_side_q;

  always_ff @(posedge clk_i) begin
    if (f1_rdy && sq_out_valid) begin
      f1_inset_q <= inset_d;
      f1_side_q  <= sq_side;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: move both ends inward, flag empty spans
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] f1_left, f1_right, inset_x, x1, x2;
  logic                 f1_empty;

  assign f1_left  = f1_side_q.left;
  assign f1_right = f1_side_q.right;
  assign inset_x  = XW'(f1_inset_q);
  assign x1       = f1_left + inset_x;
  assign x2       = f1_right - inset_x;
  assign f1_empty = (f1_side_q.mode == MODE_EMPTY);

  logic [COORD_BITS-1:0] out_left_q, out_right_q;
  logic                  out_flag_q;

  always_ff @(posedge clk_i) begin
    if (out_rdy && f1_v_q) begin
      out_left_q  <= f1_empty ? '0 : x1[COORD_BITS-1:0];
      out_right_q <= f1_empty ? '0 : x2[COORD_BITS-1:0];
      out_flag_q  <= !f1_empty && (x1 <= x2);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = TDATA_OUT_W'({out_right_q, out_left_q});
  assign m_axis_tuser  = out_flag_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_root_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fv_q[2] && s3_side_q.mode == MODE_ROOT |-> s3_dy_q != '0 && s3_dy_q < s3_r_q)
    else $error("root mode with row distance outside the corner band");

  a_root_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_out_valid && sq_side.mode == MODE_ROOT |-> sq_root <= sq_side.r_m1)
    else $error("square root larger than radius minus one");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready)
    else $error("row stream blocked while output register is empty");

endmodule

`default_nettype wire

// ===== test/rounded_rect_row_span_unit_test.sv =====
// Self-checking testbench for the rounded rectangle row span unit: directed and random rows.
`default_nettype none

module rounded_rect_row_span_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrs_pkg::*;

  // Stop the run once this many cycles go by without any request moving on any channel.
  localparam int STALL_LIMIT = 2000;
  // Number of register stages between the row port and the span port.
  localparam int PIPE_DEPTH  = 18;
  localparam int RANDOM_SETS = 20;
  localparam int ROWS_PER_SET = 95;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] right;
    logic                         valid;
  } span_t;

  // Keeps its own copy of the rectangle and a queue of spans still owed by the block.
  class span_scoreboard;
    logic signed [POS_W-1:0] rect_left;
    logic signed [POS_W-1:0] rect_top;
    logic [DIM_W-1:0]        rect_width;
    logic [DIM_W-1:0]        rect_height;
    logic [DIM_W-1:0]        corner_radius;
    span_t                   owed_spans[$];
    int                      mismatches;
    int                      rows_seen;
    int                      spans_checked;

    function new();
      rect_left = '0;
      rect_top = '0;
      rect_width = '0;
      rect_height = '0;
      corner_radius = '0;
      mismatches = 0;
      rows_seen = 0;
      spans_checked = 0;
    endfunction

    // Drop writes to indexes past the register list, as the block does.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RECT_LEFT:     rect_left = data[POS_W-1:0];
        REG_RECT_TOP:      rect_top = data[POS_W-1:0];
        REG_RECT_WIDTH:    rect_width = data[DIM_W-1:0];
        REG_RECT_HEIGHT:   rect_height = data[DIM_W-1:0];
        REG_CORNER_RADIUS: corner_radius = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Bit-by-bit integer square root, two radicand bits per step.
    function int unsigned int_sqrt(int unsigned v);
      int unsigned rem;
      int unsigned root;
      int unsigned probe;
      rem = v;
      root = 0;
      probe = 32'd1 << 30;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem -= root + probe;
          root += probe << 1;
        end
        root >>= 1;
        probe >>= 2;
      end
      return root;
    endfunction

    function span_t row_span(logic [COORD_BITS-1:0] row);
      int    y;
      int    left;
      int    top;
      int    bottom;
      int    r;
      int    maxr;
      int    cy_top;
      int    cy_bot;
      int    dy;
      int    inset;
      int    x1;
      int    x2;
      span_t s;
      s = '0;
      if (rect_width == 0 || rect_height == 0) return s;
      y = $signed(row);
      left = rect_left;
      top = rect_top;
      bottom = top + int'(rect_height) - 1;
      maxr = rect_width / 2;
      if (rect_height / 2 < maxr) maxr = rect_height / 2;
      r = corner_radius;
      if (r > maxr) r = maxr;
      inset = 0;
      if (r != 0) begin
        cy_top = top + r - 1;
        cy_bot = bottom - (r - 1);
        dy = 0;
        if (y < cy_top) dy = cy_top - y;
        else if (y > cy_bot) dy = y - cy_bot;
        // Rows at or past the corner radius (and rows off the rectangle) take the full inset.
        if (dy >= r) inset = r - 1;
        else if (dy > 0) begin
          inset = (r - 1) - int'(int_sqrt(r * r - dy * dy));
          if (inset < 0) inset = 0;
          if (inset > r - 1) inset = r - 1;
        end
      end
      x1 = left + inset;
      x2 = left + int'(rect_width) - 1 - inset;
      s.left = COORD_BITS'(x1);
      s.right = COORD_BITS'(x2);
      s.valid = (x1 <= x2);
      return s;
    endfunction

    function void note_row(logic [COORD_BITS-1:0] row);
      owed_spans.push_back(row_span(row));
      rows_seen++;
    endfunction

    function void check_span(logic [TDATA_OUT_W-1:0] data, logic [0:0] user);
      span_t want;
      span_t got;
      got.left = data[COORD_BITS-1:0];
      got.right = data[2*COORD_BITS-1:COORD_BITS];
      got.valid = user[0];
      spans_checked++;
      if (owed_spans.size() == 0) begin
        $error("span request with no row outstanding: left %0d right %0d valid %0b",
               got.left, got.right, got.valid);
        mismatches++;
        return;
      end
      want = owed_spans.pop_front();
      if (got.left !== want.left) begin
        $error("span_left: expected %0d, got %0d", want.left, got.left);
        mismatches++;
      end
      if (got.right !== want.right) begin
        $error("span_right: expected %0d, got %0d", want.right, got.right);
        mismatches++;
      end
      if (got.valid !== want.valid) begin
        $error("span_valid: expected %0b, got %0b", want.valid, got.valid);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [TDATA_IN_W-1:0]    s_axis_tdata;   // row_y
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [TDATA_OUT_W-1:0]   m_axis_tdata;   // span_left, span_right
  logic [0:0]               m_axis_tuser;   // span_valid

  span_scoreboard spans = new();
  int             quiet_cycles = 0;
  int             rect_settings = 0;
  bit             steady = 1'b0;   // no idling on either side while set

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rounded_rect_row_span_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Mostly short gaps, now and then a long one; none while the steady flag is up.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Watch every channel at the edge; predict on accepted rows, check accepted spans.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) spans.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) spans.note_row(s_axis_tdata[COORD_BITS-1:0]);
      if (m_axis_tvalid && m_axis_tready) spans.check_span(m_axis_tdata, m_axis_tuser);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Span sink: hold ready for a stretch, then stall for a random gap.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      begin : sink_stall
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("rounded_rect_row_span_unit_test: errors");
    $finish;
  end

  // Leave valid high after the write so back-to-back writes never lower and raise it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Hold the row until taken, then idle for a random gap. The row wraps to the coordinate width.
  task automatic send_row(int row);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_IN_W - COORD_BITS){1'b0}}, COORD_BITS'(row)};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop the row valid, then wait on the clock until every owed span is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (spans.owed_spans.size() != 0);
  endtask

  // Load a whole rectangle while idle; optionally poke an index past the register list.
  task automatic set_rect(logic [CFG_DATA_W-1:0] left, logic [CFG_DATA_W-1:0] top,
                          logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                          logic [CFG_DATA_W-1:0] rad, bit stray_write);
    logic [CFG_IDX_W-1:0] stray_idx;
    drain();
    write_reg(REG_RECT_LEFT, left);
    write_reg(REG_RECT_TOP, top);
    write_reg(REG_RECT_WIDTH, w);
    write_reg(REG_RECT_HEIGHT, h);
    write_reg(REG_CORNER_RADIUS, rad);
    if (stray_write) begin
      stray_idx = REG_CORNER_RADIUS + CFG_IDX_W'($urandom_range(1, 3));
      write_reg(stray_idx, CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
    rect_settings++;
  endtask

  // Random side: often zero, mostly small, a few large up to the full 12 bits.
  // The two bits above the field are random and must be masked off by the block.
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    int p;
    logic [DIM_W-1:0] side;
    p = $urandom_range(0, 99);
    if (p < 8) side = '0;
    else if (p < 65) side = DIM_W'($urandom_range(1, 64));
    else if (p < 88) side = DIM_W'($urandom_range(65, 600));
    else side = DIM_W'($urandom_range(3000, 4095));
    return {(CFG_DATA_W - DIM_W)'($urandom), side};
  endfunction

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset: empty rectangle on every row, coordinate extremes.
    send_row(-16384);
    send_row(16383);
    send_row(0);

    // Small rectangle with an unclamped radius: rows above, in the top band,
    // at the corner centre row, in the middle, on the bottom edge and below.
    set_rect(14'd10, 14'd20, 14'd30, 14'd16, 14'd5, 1'b0);
    send_row(-16384);
    send_row(16383);
    send_row(19);
    send_row(20);
    send_row(22);
    send_row(24);
    send_row(28);
    send_row(35);
    send_row(36);

    // Radius clamps to zero on a one-row rectangle: full width everywhere.
    set_rect(14'd3, -14'sd2, 14'd7, 14'd1, 14'd9, 1'b0);
    send_row(-2);
    send_row(5);

    // Largest sides at the low corner of the plane; radius clamps to 2047.
    set_rect(-14'sd8192, -14'sd8192, 14'd4095, 14'd4095, 14'd4095, 1'b0);
    send_row(-16384);
    send_row(-8192);
    send_row(-8191);
    send_row(-6146);
    send_row(3);

    // Largest sides at the high corner; the right edge goes past the 14-bit range.
    set_rect(14'd8191, 14'd8191, 14'd4095, 14'd4095, 14'd2047, 1'b1);
    send_row(16383);
    send_row(8191);

    // Zero width with a nonzero height is still empty.
    set_rect(14'd100, 14'd100, 14'd0, 14'd5, 14'd2, 1'b1);
    send_row(101);

    for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
      logic [CFG_DATA_W-1:0] h;
      logic [CFG_DATA_W-1:0] rad;
      int                    band;
      int                    top;
      drain();
      steady = ($urandom_range(0, 3) == 0);
      h = pick_side();
      rad = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                        : CFG_DATA_W'($urandom_range(0, h[DIM_W-1:0] / 2 + 2));
      set_rect(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), pick_side(), h, rad,
               $urandom_range(0, 2) == 0);
      top = int'(spans.rect_top);
      band = int'(spans.rect_height) + 2 * int'(spans.corner_radius) + 8;
      // Most rows land in and around the rectangle; the rest anywhere on the axis.
      for (int n = 0; n < ROWS_PER_SET; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_row(int'($urandom_range(0, 32767)));
        else
          send_row(top - int'(spans.corner_radius) - 4 +
                   int'($urandom_range(0, band - 1)));
      end
    end

    drain();
    repeat (PIPE_DEPTH + 6) @(posedge clk_i);
    $display("covered %0d rows over %0d rectangle settings, %0d spans compared",
             spans.rows_seen, rect_settings, spans.spans_checked);
    if (spans.mismatches == 0 && spans.owed_spans.size() == 0) begin
      $display("rounded_rect_row_span_unit_test: clean");
    end else begin
      $display("rounded_rect_row_span_unit_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/rrs_pkg.sv
design/rrs_sqrt_pipe.sv
design/rounded_rect_row_span_unit.sv
test/rounded_rect_row_span_unit_test.sv
